/* hw/rtl/cts_pkg.sv */
package cts_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;

  localparam int unsigned SIN_STAGES  = 7;
  localparam int unsigned ISQ_OUTER_W = 64;
  localparam int unsigned ISQ_M_W     = 34;

  localparam int unsigned T_SIN   = 1 + SIN_STAGES;
  localparam int unsigned T_PQ    = T_SIN + 1;
  localparam int unsigned T_DS    = T_PQ + 1;
  localparam int unsigned T_R1    = T_DS + ISQ_OUTER_W / 2;
  localparam int unsigned T_RT    = T_R1 + 1;
  localparam int unsigned T_M2    = T_RT + 1;
  localparam int unsigned T_M     = T_M2 + ISQ_M_W / 2;
  localparam int unsigned T_F1    = T_M + 1;
  localparam int unsigned T_F2    = T_F1 + 1;
  localparam int unsigned LATENCY = T_F2 + 1;

  localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;
  localparam logic signed [33:0] SIN_C1  = 34'sd1686629713;
  localparam logic signed [33:0] SIN_C3  = 34'sd693598668;
  localparam logic signed [33:0] SIN_C5  = 34'sd85569306;
  localparam logic signed [33:0] SIN_C7  = 34'sd5026995;
  localparam logic signed [33:0] SIN_C9  = 34'sd172272;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  typedef enum logic [1:0] {
    REG_MAJOR_RADIUS = 2'd0,
    REG_OVAL_A       = 2'd1,
    REG_OVAL_B       = 2'd2
  } cfg_reg_e;

  // Product scaled by 2^-30, rounded half away from zero.
  function automatic logic signed [35:0] mul_q30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
    logic [32:0] ma;
    logic [32:0] mb;
    logic [65:0] p;
    logic [35:0] r;
    ma = a[33] ? 33'(-a) : a[32:0];
    mb = b[33] ? 33'(-b) : b[32:0];
    p  = 66'(ma) * 66'(mb);
    r  = 36'((p + (66'd1 << 29)) >> 30);
    return (a[33] ^ b[33]) ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [23:0] sat24(input logic signed [35:0] v);
    logic [23:0] r;
    if (v > 36'sd8388607) begin
      r = 24'h7F_FFFF;
    end else if (v < -36'sd8388608) begin
      r = 24'h80_0000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/cts_sine.sv */
module cts_sine (
  input  logic               clk_i,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] sin_o
);
  import cts_pkg::*;

  logic [30:0]        t0;
  logic [30:0]        t_q  [6];
  logic [1:0]         qd_q [6];
  logic signed [31:0] t2_q [4];
  logic signed [31:0] p_q  [4];
  logic signed [35:0] s_full;
  logic [30:0]        s_mag;
  logic signed [31:0] sin_q;

  assign t0 = phase_i[30] ? 31'(Q30_ONE) - 31'(phase_i[29:0]) : 31'(phase_i[29:0]);

  always_comb begin
    s_full = mul_q30(34'(p_q[3]), 34'(t_q[5]));
    if (s_full[35]) begin
      s_mag = '0;
    end else if (s_full > 36'(Q30_ONE)) begin
      s_mag = 31'(Q30_ONE);
    end else begin
      s_mag = s_full[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    t_q[0]  <= t0;
    qd_q[0] <= phase_i[31:30];
    for (int k = 1; k < 6; k++) begin
      t_q[k]  <= t_q[k-1];
      qd_q[k] <= qd_q[k-1];
    end
    t2_q[0] <= 32'(mul_q30(34'(t_q[0]), 34'(t_q[0])));
    for (int k = 1; k < 4; k++) begin
      t2_q[k] <= t2_q[k-1];
    end
    p_q[0] <= 32'(mul_q30(SIN_C9, 34'(t2_q[0])) - 36'(SIN_C7));
    p_q[1] <= 32'(mul_q30(34'(p_q[0]), 34'(t2_q[1])) + 36'(SIN_C5));
    p_q[2] <= 32'(mul_q30(34'(p_q[1]), 34'(t2_q[2])) - 36'(SIN_C3));
    p_q[3] <= 32'(mul_q30(34'(p_q[2]), 34'(t2_q[3])) + 36'(SIN_C1));
    sin_q  <= qd_q[5][1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
  end

  assign sin_o = sin_q;

endmodule

/* hw/rtl/cts_isqrt.sv */
module cts_isqrt #(
  parameter int unsigned W = 64
) (
  input  logic             clk_i,
  input  logic [W-1:0]     rad_i,
  output logic [W/2-1:0]   root_o
);
  localparam int unsigned N = W / 2;

  logic [W-1:0] rem_q [N];
  logic [N-1:0] r_q   [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned I = N - 1 - k;
    logic [W-1:0] rem_in;
    logic [N-1:0] r_in;
    logic [W-1:0] inc;

    if (k == 0) begin : g_first
      assign rem_in = rad_i;
      assign r_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign r_in   = r_q[k-1];
    end

    assign inc = (W'(r_in) << (I + 1)) | (W'(1) << (2 * I));

    always_ff @(posedge clk_i) begin
      if (rem_in >= inc) begin
        rem_q[k] <= rem_in - inc;
        r_q[k]   <= r_in | (N'(1) << I);
      end else begin
        rem_q[k] <= rem_in;
        r_q[k]   <= r_in;
      end
    end
  end

  assign root_o = r_q[N-1];

endmodule

/* hw/rtl/cassinian_torus_point_eval.sv */
// Each accepted transaction yields one result, strobed on done_o.
// Throughput: one transaction per cycle; busy_o stays low and start_i may be held high.
// The two 32-stage square root pipelines and the 17-stage one after them set most of the latency.
// The receiver cannot stall, so results leave the pipeline as they complete.
// Reset clears the valid bits and sets R, a and b to 1.0.
module cassinian_torus_point_eval #(
  parameter int unsigned ANGLE_BITS = cts_pkg::ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [15:0]           cfg_data_i,
  input  logic [ANGLE_BITS-1:0] angle_u_i,
  input  logic [ANGLE_BITS-1:0] angle_v_i,
  output logic                  done_o,
  output logic signed [23:0]    x_coord_o,
  output logic signed [23:0]    y_coord_o,
  output logic signed [23:0]    z_coord_o,
  output logic                  invalid_o
);
  import cts_pkg::*;

  localparam int unsigned D_V = T_M - T_SIN;
  localparam int unsigned D_U = T_F2 - T_SIN;
  localparam int unsigned D_P = T_RT - T_PQ;
  localparam int unsigned D_N = T_RT - T_DS;
  localparam int unsigned D_I = T_F2 - T_M2;
  localparam int unsigned RW  = ISQ_OUTER_W / 2;
  localparam int unsigned MW  = ISQ_M_W / 2;

  logic [15:0] radius_q;
  logic [15:0] oval_a_q;
  logic [15:0] oval_b_q;
  logic [31:0] a2_q;
  logic [31:0] b2_q;

  logic        vld_q [LATENCY];
  logic [31:0] ph_u_q;
  logic [31:0] ph_v_q;

  logic signed [31:0] sin_u, cos_u, sin_v, cos_v, sin_2v, cos_2v;
  logic signed [31:0] cu_dly_q [D_U];
  logic signed [31:0] su_dly_q [D_U];
  logic signed [31:0] cv_dly_q [D_V];
  logic signed [31:0] sv_dly_q [D_V];

  logic signed [33:0] p_q;
  logic [32:0]        q_q;
  logic signed [33:0] p_dly_q [D_P];
  logic signed [34:0] d_full;
  logic [31:0]        d_q;
  logic [32:0]        s_q;
  logic               negd_q;
  logic               nd_dly_q [D_N];

  logic [RW-1:0]      rd;
  logic [RW-1:0]      rs;
  logic [63:0]        rprod;
  logic [33:0]        root_q;
  logic signed [35:0] m2;
  logic [33:0]        m2_q;
  logic               inv_q;
  logic               inv_dly_q [D_I];
  logic [MW-1:0]      m;

  logic signed [19:0] mc_q;
  logic signed [19:0] z_q;
  logic signed [19:0] z2_q;
  logic signed [19:0] factor_q;
  logic               inv_out;

  logic        [23:0] x_q;
  logic        [23:0] y_q;
  logic        [23:0] zo_q;
  logic               invo_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 16'd4096;
      oval_a_q <= 16'd4096;
      oval_b_q <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MAJOR_RADIUS: radius_q <= cfg_data_i;
        REG_OVAL_A:       oval_a_q <= cfg_data_i;
        REG_OVAL_B:       oval_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LATENCY; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= start_i & ~busy_o;
      for (int k = 1; k < LATENCY; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a2_q   <= 32'(oval_a_q) * 32'(oval_a_q);
    b2_q   <= 32'(oval_b_q) * 32'(oval_b_q);
    ph_u_q <= 32'(angle_u_i) << (32 - ANGLE_BITS);
    ph_v_q <= 32'(angle_v_i) << (32 - ANGLE_BITS);
  end

  cts_sine u_sin_u  (.clk_i(clk_i), .phase_i(ph_u_q),                .sin_o(sin_u));
  cts_sine u_cos_u  (.clk_i(clk_i), .phase_i(ph_u_q + QUARTER_TURN), .sin_o(cos_u));
  cts_sine u_sin_v  (.clk_i(clk_i), .phase_i(ph_v_q),                .sin_o(sin_v));
  cts_sine u_cos_v  (.clk_i(clk_i), .phase_i(ph_v_q + QUARTER_TURN), .sin_o(cos_v));
  cts_sine u_sin_2v (.clk_i(clk_i), .phase_i(ph_v_q << 1),           .sin_o(sin_2v));
  cts_sine u_cos_2v (
    .clk_i  (clk_i),
    .phase_i((ph_v_q << 1) + QUARTER_TURN),
    .sin_o  (cos_2v)
  );

  assign d_full = 35'(b2_q) - 35'(q_q);

  always_ff @(posedge clk_i) begin
    cu_dly_q[0] <= cos_u;
    su_dly_q[0] <= sin_u;
    for (int k = 1; k < D_U; k++) begin
      cu_dly_q[k] <= cu_dly_q[k-1];
      su_dly_q[k] <= su_dly_q[k-1];
    end
    cv_dly_q[0] <= cos_v;
    sv_dly_q[0] <= sin_v;
    for (int k = 1; k < D_V; k++) begin
      cv_dly_q[k] <= cv_dly_q[k-1];
      sv_dly_q[k] <= sv_dly_q[k-1];
    end

    p_q <= 34'(mul_q30(34'(a2_q), 34'(cos_2v)));
    q_q <= 33'(mul_q30(34'(a2_q), 34'(sin_2v[31] ? -sin_2v : sin_2v)));

    p_dly_q[0] <= p_q;
    for (int k = 1; k < D_P; k++) begin
      p_dly_q[k] <= p_dly_q[k-1];
    end

    negd_q <= d_full[34];
    d_q    <= d_full[34] ? '0 : d_full[31:0];
    s_q    <= 33'(b2_q) + q_q;

    nd_dly_q[0] <= negd_q;
    for (int k = 1; k < D_N; k++) begin
      nd_dly_q[k] <= nd_dly_q[k-1];
    end
  end

  cts_isqrt #(.W(ISQ_OUTER_W)) u_isqrt_d (
    .clk_i (clk_i),
    .rad_i (ISQ_OUTER_W'({d_q, 30'b0})),
    .root_o(rd)
  );

  cts_isqrt #(.W(ISQ_OUTER_W)) u_isqrt_s (
    .clk_i (clk_i),
    .rad_i (ISQ_OUTER_W'({s_q, 30'b0})),
    .root_o(rs)
  );

  assign rprod = 64'(rd) * 64'(rs);
  assign m2    = 36'(p_dly_q[D_P-1]) + $signed({2'b0, root_q});

  always_ff @(posedge clk_i) begin
    root_q <= 34'((rprod + (64'd1 << 29)) >> 30);
    m2_q   <= m2[35] ? '0 : m2[33:0];
    inv_q  <= m2[35] | nd_dly_q[D_N-1];
    inv_dly_q[0] <= inv_q;
    for (int k = 1; k < D_I; k++) begin
      inv_dly_q[k] <= inv_dly_q[k-1];
    end
  end

  cts_isqrt #(.W(ISQ_M_W)) u_isqrt_m (
    .clk_i (clk_i),
    .rad_i (m2_q),
    .root_o(m)
  );

  assign inv_out = inv_dly_q[D_I-1];

  always_ff @(posedge clk_i) begin
    mc_q     <= 20'(mul_q30(34'(m), 34'(cv_dly_q[D_V-1])));
    z_q      <= 20'(mul_q30(34'(m), 34'(sv_dly_q[D_V-1])));
    factor_q <= 20'(radius_q) + mc_q;
    z2_q     <= z_q;
    x_q      <= inv_out ? '0 : sat24(mul_q30(34'(factor_q), 34'(cu_dly_q[D_U-1])));
    y_q      <= inv_out ? '0 : sat24(mul_q30(34'(factor_q), 34'(su_dly_q[D_U-1])));
    zo_q     <= inv_out ? '0 : sat24(36'(z2_q));
    invo_q   <= inv_out;
  end

  assign done_o    = vld_q[LATENCY-1];
  assign x_coord_o = x_q;
  assign y_coord_o = y_q;
  assign z_coord_o = zo_q;
  assign invalid_o = invo_q;

endmodule

/* hw/rtl/cts_checker.sv */
module cts_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_i,
  input logic               done_i,
  input logic               invalid_i,
  input logic signed [23:0] x_coord_i,
  input logic signed [23:0] y_coord_i,
  input logic signed [23:0] z_coord_i
);
  import cts_pkg::*;

  // Every accepted transaction yields exactly one result after the fixed latency.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |-> ##LATENCY done_i)
    else $error("result missing after accepted transaction");

  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(start_i && !busy_i, LATENCY))
    else $error("result without an accepted transaction");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && invalid_i) |-> (x_coord_i == 0 && y_coord_i == 0 && z_coord_i == 0))
    else $error("invalid result carries non-zero coordinates");

endmodule

bind cassinian_torus_point_eval cts_checker u_cts_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_i   (busy_o),
  .done_i   (done_o),
  .invalid_i(invalid_o),
  .x_coord_i(x_coord_o),
  .y_coord_i(y_coord_o),
  .z_coord_i(z_coord_o)
);

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cts_pkg::*;

  localparam int unsigned PIPE_DEPTH = 64;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam longint SINE_ONE = 64'sd1073741824;
  localparam longint COEF_1 = 64'sd1686629713;
  localparam longint COEF_3 = 64'sd693598668;
  localparam longint COEF_5 = 64'sd85569306;
  localparam longint COEF_7 = 64'sd5026995;
  localparam longint COEF_9 = 64'sd172272;

  typedef struct packed {
    logic [15:0] u;
    logic [15:0] v;
  } angle_pair_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               invalid;
  } surface_point_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [15:0]        cfg_data_i;
  logic [15:0]        angle_u_i;
  logic [15:0]        angle_v_i;
  logic               done_o;
  logic signed [23:0] x_coord_o;
  logic signed [23:0] y_coord_o;
  logic signed [23:0] z_coord_o;
  logic               invalid_o;

  angle_pair_t    angle_pending[$];
  surface_point_t point_expected[$];
  logic [15:0]    radius_r = 16'd4096;
  logic [15:0]    focal_a = 16'd4096;
  logic [15:0]    product_b = 16'd4096;
  int unsigned    sender_gap_pct = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    error_count = 0;

  cassinian_torus_point_eval dut (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint scale_q30(longint a, longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned p;
    longint r;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = ma * mb;
    r = longint'((p + (64'd1 << 29)) >> 30);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned bit_w;
    r = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w >>= 2;
    while (bit_w != 0) begin
      if (n >= r + bit_w) begin
        n -= r + bit_w;
        r = (r >> 1) + bit_w;
      end else begin
        r >>= 1;
      end
      bit_w >>= 2;
    end
    return r;
  endfunction

  function automatic longint phase_sine(logic [31:0] ph);
    longint t;
    longint t2;
    longint p;
    longint s;
    t = longint'(ph[29:0]);
    if (ph[30]) t = SINE_ONE - t;
    t2 = scale_q30(t, t);
    p = COEF_9;
    p = scale_q30(p, t2) - COEF_7;
    p = scale_q30(p, t2) + COEF_5;
    p = scale_q30(p, t2) - COEF_3;
    p = scale_q30(p, t2) + COEF_1;
    s = scale_q30(p, t);
    if (s < 0) s = 0;
    if (s > SINE_ONE) s = SINE_ONE;
    return ph[31] ? -s : s;
  endfunction

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic surface_point_t torus_point(logic [15:0] u, logic [15:0] v);
    logic [31:0]     pu;
    logic [31:0]     pv;
    logic [31:0]     p2v;
    longint          a2;
    longint          b2;
    longint          pc;
    longint          qs;
    longint          dif;
    longint          sum;
    longint          m2;
    longint          m;
    longint          factor;
    longint          qabs;
    longint unsigned root;
    surface_point_t  pt;
    pu = {u, 16'd0};
    pv = {v, 16'd0};
    p2v = pv << 1;
    pt = '0;
    a2 = longint'(focal_a) * longint'(focal_a);
    b2 = longint'(product_b) * longint'(product_b);
    pc = scale_q30(a2, phase_sine(p2v + QUARTER_TURN));
    qabs = phase_sine(p2v);
    if (qabs < 0) qabs = -qabs;
    qs = scale_q30(a2, qabs);
    dif = b2 - qs;
    sum = b2 + qs;
    if (dif < 0) begin
      pt.invalid = 1'b1;
      return pt;
    end
    root = (floor_sqrt(longint'(dif) << 30) * floor_sqrt(longint'(sum) << 30)
            + (64'd1 << 29)) >> 30;
    m2 = pc + longint'(root);
    if (m2 < 0) begin
      pt.invalid = 1'b1;
      return pt;
    end
    m = longint'(floor_sqrt(m2));
    factor = longint'(radius_r) + scale_q30(m, phase_sine(pv + QUARTER_TURN));
    pt.x = clamp24(scale_q30(factor, phase_sine(pu + QUARTER_TURN)));
    pt.y = clamp24(scale_q30(factor, phase_sine(pu)));
    pt.z = clamp24(scale_q30(m, phase_sine(pv)));
    return pt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      angle_u_i <= '0;
      angle_v_i <= '0;
    end else if (start_i && busy_o) begin
      start_i <= 1'b1;
    end else begin
      angle_pair_t nxt;
      if (start_i) point_expected.push_back(torus_point(angle_u_i, angle_v_i));
      if (angle_pending.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
        nxt = angle_pending.pop_front();
        start_i <= 1'b1;
        angle_u_i <= nxt.u;
        angle_v_i <= nxt.v;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
      if (done_o) begin
        surface_point_t ex;
        if (point_expected.size() == 0) begin
          $error("unexpected result strobe");
          error_count++;
        end else begin
          ex = point_expected.pop_front();
          if (x_coord_o !== ex.x) begin
            $error("x_coord expected %0d actual %0d", ex.x, x_coord_o);
            error_count++;
          end
          if (y_coord_o !== ex.y) begin
            $error("y_coord expected %0d actual %0d", ex.y, y_coord_o);
            error_count++;
          end
          if (z_coord_o !== ex.z) begin
            $error("z_coord expected %0d actual %0d", ex.z, z_coord_o);
            error_count++;
          end
          if (invalid_o !== ex.invalid) begin
            $error("invalid expected %0b actual %0b", ex.invalid, invalid_o);
            error_count++;
          end
        end
      end
    end
  end

  task automatic queue_angles(logic [15:0] u, logic [15:0] v);
    angle_pending.push_back('{u: u, v: v});
  endtask

  task automatic drain_pipeline();
    do @(posedge clk_i);
    while (angle_pending.size() != 0 || start_i || point_expected.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MAJOR_RADIUS: radius_r = val;
      REG_OVAL_A:       focal_a = val;
      REG_OVAL_B:       product_b = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_shape(logic [15:0] r, logic [15:0] a, logic [15:0] b);
    write_reg(REG_MAJOR_RADIUS, r);
    write_reg(REG_OVAL_A, a);
    write_reg(REG_OVAL_B, b);
  endtask

  task automatic queue_random(int unsigned n);
    logic [15:0] specials[8] = '{16'h0000, 16'hFFFF, 16'h2000, 16'h4000,
                                 16'h8000, 16'hC000, 16'h6000, 16'hE000};
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        queue_angles(specials[3'($urandom_range(7))], specials[3'($urandom_range(7))]);
      else
        queue_angles(16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    int unsigned gap_plan[4] = '{0, 51, 0, 33};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (gap_plan[k]) queue_angles(16'(k) << 14, 16'(k) << 14);
    queue_angles(16'hFFFF, 16'hFFFF);
    queue_angles(16'h2000, 16'h2000);
    queue_angles(16'h1234, 16'h6000);
    drain_pipeline();

    set_shape(16'd4096, 16'd8192, 16'd4096);
    queue_angles(16'h0000, 16'h2000);
    queue_angles(16'h4000, 16'h4000);
    queue_angles(16'h8000, 16'h0000);
    queue_angles(16'hC000, 16'hC000);
    queue_angles(16'h1111, 16'h0400);
    drain_pipeline();

    write_reg(REG_UNUSED, 16'h0000);
    set_shape(16'd0, 16'd0, 16'd0);
    queue_angles(16'h0000, 16'h0000);
    queue_angles(16'hFFFF, 16'h8000);
    drain_pipeline();

    set_shape(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_angles(16'h0000, 16'h0000);
    queue_angles(16'hFFFF, 16'hFFFF);
    queue_angles(16'h4000, 16'h2000);
    queue_angles(16'h8000, 16'hC000);
    drain_pipeline();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_shape(16'd4096, 16'd4096, 16'd4096);
        1: set_shape(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: set_shape(16'd0, 16'd0, 16'd0);
        3: set_shape(16'd8192, 16'd6000, 16'd4096);
        4: set_shape(16'd20000, 16'd4096, 16'd6000);
        default: set_shape(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      sender_gap_pct = gap_plan[ph % 4];
      queue_random(120);
      if (ph == 1) drain_pipeline();
      queue_random(120);
      drain_pipeline();
    end

    repeat (PIPE_DEPTH + 10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
